// ===== rtl/planar_odometry_integrator_assert.svh =====
// Assertion macros for the planar odometry integrator.
// Used by the top level only; expands to nothing under synthesis.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define POI_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("planar_odometry_integrator assertion failed");
// Next-cycle implication.
`define POI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("planar_odometry_integrator assertion failed");
`else
`define POI_ASSERT_IMP(name, clk, rst, ante, cons)
`define POI_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/poi_pkg.sv =====
// Shared types and constants of the planar odometry integrator.
// No dependencies; used by poi_mul and planar_odometry_integrator.
package poi_pkg;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [23:0] WD_LIMIT_RESET = 24'd6554;

   // Quarter-wave sine polynomial coefficients, Q1.15 scaled.
   localparam logic [15:0] POLY_C2 = 16'd2320;
   localparam logic [15:0] POLY_C1 = 16'd21024;
   localparam logic [15:0] POLY_C0 = 16'd51472;
   localparam logic [16:0] TRIG_MAX = 17'd32767;
   localparam logic [10:0] QUARTER_STEPS = 11'd1024;

   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MS1, ST_MC1, ST_MS2, ST_MC2, ST_MS3, ST_MC3, ST_MS4, ST_MC4,
      ST_V1, ST_V2, ST_V3, ST_V4,
      ST_HDG, ST_XL, ST_XH, ST_YL, ST_YH,
      ST_FX, ST_FY,
      ST_DONE
   } poi_state_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } poi_mul_op_type;

endpackage

// ===== rtl/planar_odometry_integrator.sv =====
// Planar odometry integrator: dead-reckons x, y and heading from body-frame
// velocity commands. A command item (opcode 0) latches the velocities without
// stalling the input and produces no result. A tick item (opcode 1) keeps the
// input stalled from its acceptance until the block returns to idle:
// seventeen products are issued one per cycle through a single 33x18 signed
// multiplier (quarter-wave sine polynomial for sin and cos, velocity rotation,
// the time scaling of x, y and heading), followed by the two position adds
// and a commit state. The tick's result is held in an output register; the
// tick waits in its commit state while that register is still occupied and
// stalled, and the input stays stalled while it waits.
// Depends on poi_pkg, poi_mul and planar_odometry_integrator_assert.svh.
`include "planar_odometry_integrator_assert.svh"

module planar_odometry_integrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [23:0] req_cmd_forward,
   input  logic [23:0] req_cmd_lateral,
   input  logic [31:0] req_cmd_turn_rate,
   input  logic [15:0] req_elapsed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [47:0] rsp_pos_x,
   output logic [47:0] rsp_pos_y,
   output logic [31:0] rsp_heading,
   output logic [23:0] rsp_eff_forward,
   output logic [23:0] rsp_eff_lateral,
   output logic [31:0] rsp_eff_turn_rate,
   output logic        rsp_stopped,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);
   import poi_pkg::*;

   poi_state_type state_ff;
   poi_state_type state_in;

   // Architectural state.
   logic [23:0] limit_ff;
   logic [23:0] held_fwd_ff;
   logic [23:0] held_lat_ff;
   logic [31:0] held_turn_ff;
   logic [23:0] since_ff;
   logic [47:0] pos_x_ff;
   logic [47:0] pos_y_ff;
   logic [31:0] heading_ff;

   // Working registers of one tick.
   logic [15:0] dt_ff;
   logic        stopped_ff;
   logic [1:0]  quad_ff;
   logic [15:0] zs_ff;
   logic [15:0] zc_ff;
   logic [15:0] z2s_ff;
   logic [15:0] z2c_ff;
   logic [15:0] ts_ff;
   logic [15:0] tc_ff;
   logic [16:0] sin_ff;
   logic [16:0] cos_ff;
   logic [41:0] xsum_ff;
   logic [41:0] ysum_ff;
   logic [36:0] lo_prod_ff;
   logic [57:0] full_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [47:0] rsp_pos_x_ff;
   logic [47:0] rsp_pos_y_ff;
   logic [31:0] rsp_heading_ff;
   logic [23:0] rsp_fwd_ff;
   logic [23:0] rsp_lat_ff;
   logic [31:0] rsp_turn_ff;
   logic        rsp_stopped_ff;

   logic               cmd_acc;
   logic               tick_acc;
   logic               out_free;
   logic [24:0]        since_sum;
   logic [23:0]        since_sat;
   logic               wd_trip;
   logic [11:0]        trig_idx;
   logic [10:0]        m_fwd;
   logic [10:0]        m_rev;
   logic [10:0]        ms;
   logic [10:0]        mc;
   poi_mul_op_type     mul_op;
   logic [MUL_P_W-1:0] prod;
   logic [17:0]        p_raw;
   logic [16:0]        p_clamp;
   logic [16:0]        p_neg;
   logic [57:0]        full_sum;
   logic               eff_zero;

   assign req_stall = (state_ff != ST_IDLE);
   assign cmd_acc   = req_valid && !req_stall && (req_opcode == OP_COMMAND);
   assign tick_acc  = req_valid && !req_stall && (req_opcode == OP_TICK);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign since_sum = {1'b0, since_ff} + {9'b0, req_elapsed};
   assign since_sat = since_sum[24] ? '1 : since_sum[23:0];
   assign wd_trip   = (since_sat > limit_ff);

   // Sine of index i uses step k in even quadrants and 1024-k in odd ones;
   // cosine is one quadrant on, so it takes the other of the two.
   assign trig_idx = heading_ff[31:20];
   assign m_fwd    = {1'b0, trig_idx[9:0]};
   assign m_rev    = QUARTER_STEPS - m_fwd;
   assign ms       = trig_idx[10] ? m_rev : m_fwd;
   assign mc       = trig_idx[10] ? m_fwd : m_rev;

   // Polynomial result, clamped at the quadrant edge where it reaches 1.0.
   assign p_raw   = prod[32:15];
   assign p_clamp = (p_raw[17:15] != 3'b0) ? TRIG_MAX : p_raw[16:0];
   assign p_neg   = 17'd0 - p_clamp;

   // Rebuild a 42x16 product from its low and high partial products.
   assign full_sum = {prod[36:0], 21'b0} + {21'b0, lo_prod_ff};

   poi_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_op.a = '0;
      mul_op.b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_acc) begin
               state_in = ST_MS1;
            end
         end
         ST_MS1: begin
            mul_op.a = {17'b0, zs_ff};
            mul_op.b = {2'b0, zs_ff};
            state_in = ST_MC1;
         end
         ST_MC1: begin
            mul_op.a = {17'b0, zc_ff};
            mul_op.b = {2'b0, zc_ff};
            state_in = ST_MS2;
         end
         ST_MS2: begin
            mul_op.a = {17'b0, POLY_C2};
            mul_op.b = {2'b0, z2s_ff};
            state_in = ST_MC2;
         end
         ST_MC2: begin
            mul_op.a = {17'b0, POLY_C2};
            mul_op.b = {2'b0, z2c_ff};
            state_in = ST_MS3;
         end
         ST_MS3: begin
            mul_op.a = {17'b0, POLY_C1 - ts_ff};
            mul_op.b = {2'b0, z2s_ff};
            state_in = ST_MC3;
         end
         ST_MC3: begin
            mul_op.a = {17'b0, POLY_C1 - tc_ff};
            mul_op.b = {2'b0, z2c_ff};
            state_in = ST_MS4;
         end
         ST_MS4: begin
            mul_op.a = {17'b0, POLY_C0 - ts_ff};
            mul_op.b = {2'b0, zs_ff};
            state_in = ST_MC4;
         end
         ST_MC4: begin
            mul_op.a = {17'b0, POLY_C0 - tc_ff};
            mul_op.b = {2'b0, zc_ff};
            state_in = ST_V1;
         end
         ST_V1: begin
            mul_op.a = {{9{held_fwd_ff[23]}}, held_fwd_ff};
            mul_op.b = {sin_ff[16], sin_ff};
            state_in = ST_V2;
         end
         ST_V2: begin
            mul_op.a = {{9{held_lat_ff[23]}}, held_lat_ff};
            mul_op.b = {sin_ff[16], sin_ff};
            state_in = ST_V3;
         end
         ST_V3: begin
            mul_op.a = {{9{held_fwd_ff[23]}}, held_fwd_ff};
            mul_op.b = {cos_ff[16], cos_ff};
            state_in = ST_V4;
         end
         ST_V4: begin
            mul_op.a = {{9{held_lat_ff[23]}}, held_lat_ff};
            mul_op.b = {cos_ff[16], cos_ff};
            state_in = ST_HDG;
         end
         ST_HDG: begin
            mul_op.a = {held_turn_ff[31], held_turn_ff};
            mul_op.b = {2'b0, dt_ff};
            state_in = ST_XL;
         end
         ST_XL: begin
            mul_op.a = {12'b0, xsum_ff[20:0]};
            mul_op.b = {2'b0, dt_ff};
            state_in = ST_XH;
         end
         ST_XH: begin
            mul_op.a = {{12{xsum_ff[41]}}, xsum_ff[41:21]};
            mul_op.b = {2'b0, dt_ff};
            state_in = ST_YL;
         end
         ST_YL: begin
            mul_op.a = {12'b0, ysum_ff[20:0]};
            mul_op.b = {2'b0, dt_ff};
            state_in = ST_YH;
         end
         ST_YH: begin
            mul_op.a = {{12{ysum_ff[41]}}, ysum_ff[41:21]};
            mul_op.b = {2'b0, dt_ff};
            state_in = ST_FX;
         end
         ST_FX: begin
            state_in = ST_FY;
         end
         ST_FY: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The watchdog acts as the tick is accepted, so the sequence below sees
   // the velocities already zeroed.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= WD_LIMIT_RESET;
         held_fwd_ff  <= '0;
         held_lat_ff  <= '0;
         held_turn_ff <= '0;
         since_ff     <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd_acc) begin
            held_fwd_ff  <= req_cmd_forward;
            held_lat_ff  <= req_cmd_lateral;
            held_turn_ff <= req_cmd_turn_rate;
            since_ff     <= '0;
         end
         if (tick_acc) begin
            since_ff <= since_sat;
            if (wd_trip) begin
               held_fwd_ff  <= '0;
               held_lat_ff  <= '0;
               held_turn_ff <= '0;
            end
         end
         if (state_ff == ST_XL) begin
            heading_ff <= heading_ff + prod[39:8];
         end
         if (state_ff == ST_FX) begin
            pos_x_ff <= pos_x_ff + {{13{full_ff[57]}}, full_ff[57:23]};
         end
         if (state_ff == ST_FY) begin
            pos_y_ff <= pos_y_ff + {{13{full_ff[57]}}, full_ff[57:23]};
         end
      end
   end

   // Each step captures the product issued in the step before it.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_acc) begin
               dt_ff      <= req_elapsed;
               stopped_ff <= wd_trip;
               quad_ff    <= trig_idx[11:10];
               zs_ff      <= {ms, 5'b0};
               zc_ff      <= {mc, 5'b0};
            end
         end
         ST_MC1: z2s_ff <= prod[30:15];
         ST_MS2: z2c_ff <= prod[30:15];
         ST_MC2: ts_ff  <= prod[30:15];
         ST_MS3: tc_ff  <= prod[30:15];
         ST_MC3: ts_ff  <= prod[30:15];
         ST_MS4: tc_ff  <= prod[30:15];
         ST_MC4: sin_ff <= quad_ff[1] ? p_neg : p_clamp;
         ST_V1:  cos_ff <= (quad_ff[1] ^ quad_ff[0]) ? p_neg : p_clamp;
         ST_V2:  ysum_ff <= prod[41:0];
         ST_V3:  xsum_ff <= 42'd0 - prod[41:0];
         ST_V4:  xsum_ff <= xsum_ff + prod[41:0];
         ST_HDG: ysum_ff <= ysum_ff + prod[41:0];
         ST_XH:  lo_prod_ff <= prod[36:0];
         ST_YL:  full_ff <= full_sum;
         ST_YH:  lo_prod_ff <= prod[36:0];
         ST_FX:  full_ff <= full_sum;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_pos_x_ff   <= pos_x_ff;
         rsp_pos_y_ff   <= pos_y_ff;
         rsp_heading_ff <= heading_ff;
         rsp_fwd_ff     <= held_fwd_ff;
         rsp_lat_ff     <= held_lat_ff;
         rsp_turn_ff    <= held_turn_ff;
         rsp_stopped_ff <= stopped_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = rsp_pos_x_ff;
   assign rsp_pos_y         = rsp_pos_y_ff;
   assign rsp_heading       = rsp_heading_ff;
   assign rsp_eff_forward   = rsp_fwd_ff;
   assign rsp_eff_lateral   = rsp_lat_ff;
   assign rsp_eff_turn_rate = rsp_turn_ff;
   assign rsp_stopped       = rsp_stopped_ff;

   assign eff_zero = (rsp_eff_forward == '0) && (rsp_eff_lateral == '0) &&
                     (rsp_eff_turn_rate == '0);

   `POI_ASSERT_NEXT(a_cmd_single_cycle, clock, reset, cmd_acc, !req_stall)
   `POI_ASSERT_NEXT(a_tick_busy, clock, reset, tick_acc, req_stall)
   `POI_ASSERT_IMP(a_stop_zero, clock, reset, rsp_valid && rsp_stopped, eff_zero)
   `POI_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid), $past(state_ff == ST_DONE))

endmodule

// ===== rtl/poi_mul.sv =====
// Shared signed multiplier of the odometry integrator with a registered product.
// Depends on poi_pkg for operand widths and the operand struct.
module poi_mul (
   input  logic                         clock,
   input  poi_pkg::poi_mul_op_type      op,
   output logic [poi_pkg::MUL_P_W-1:0]  prod
);
   import poi_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'($signed(op.a) * $signed(op.b));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== sim/planar_odometry_integrator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for planar_odometry_integrator: a cycle-free predictor of the
// dead-reckoned pose checks every tick result under random sender gaps and receiver stalls.
// Depends on poi_pkg and the planar_odometry_integrator RTL.
module planar_odometry_integrator_tb;
   import poi_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 140;
   localparam int HOLD_OFF_CYCLES = 400;

   // Quarter-wave sine polynomial, Q1.15.
   localparam longint SIN_K2 = 2320;
   localparam longint SIN_K1 = 21024;
   localparam longint SIN_K0 = 51472;
   localparam longint SIN_CLAMP = 32767;

   typedef struct packed {
      logic        op;
      logic [23:0] fwd;
      logic [23:0] lat;
      logic [31:0] turn;
      logic [15:0] elapsed;
   } odo_item_type;

   typedef struct packed {
      logic [47:0] x;
      logic [47:0] y;
      logic [31:0] heading;
      logic [23:0] fwd;
      logic [23:0] lat;
      logic [31:0] turn;
      logic        stopped;
   } pose_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_opcode = OP_COMMAND;
   logic [23:0] req_cmd_forward = '0;
   logic [23:0] req_cmd_lateral = '0;
   logic [31:0] req_cmd_turn_rate = '0;
   logic [15:0] req_elapsed = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [47:0] rsp_pos_x;
   logic [47:0] rsp_pos_y;
   logic [31:0] rsp_heading;
   logic [23:0] rsp_eff_forward;
   logic [23:0] rsp_eff_lateral;
   logic [31:0] rsp_eff_turn_rate;
   logic        rsp_stopped;

   // Predicted state of the integrator.
   logic [47:0]        est_x = '0;
   logic [47:0]        est_y = '0;
   logic [31:0]        est_heading = '0;
   logic signed [23:0] held_fwd = '0;
   logic signed [23:0] held_lat = '0;
   logic signed [31:0] held_turn = '0;
   logic [23:0]        quiet_time = '0;
   logic [23:0]        wd_limit = WD_LIMIT_RESET;
   pose_type           expected_poses[$];

   int             failures = 0;
   int             poses_checked = 0;
   int             command_count = 0;
   int             tick_count = 0;
   int             trip_count = 0;
   int             limit_writes = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   bit             sender_gaps = 1'b1;
   int             hold_request = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   int             stall_phase = 0;
   stall_mode_type stall_mode = STALL_NONE;
   pose_type       want;

   planar_odometry_integrator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_cmd_forward(req_cmd_forward),
      .req_cmd_lateral(req_cmd_lateral),
      .req_cmd_turn_rate(req_cmd_turn_rate),
      .req_elapsed(req_elapsed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_heading(rsp_heading),
      .rsp_eff_forward(rsp_eff_forward),
      .rsp_eff_lateral(rsp_eff_lateral),
      .rsp_eff_turn_rate(rsp_eff_turn_rate),
      .rsp_stopped(rsp_stopped),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint quarter_wave(input int unsigned ramp);
      longint z, z2, t;
      z = longint'(ramp) * 32;
      z2 = (z * z) >>> 15;
      t = (SIN_K2 * z2) >>> 15;
      t = ((SIN_K1 - t) * z2) >>> 15;
      t = ((SIN_K0 - t) * z) >>> 15;
      return (t > SIN_CLAMP) ? SIN_CLAMP : t;
   endfunction

   // Sine of a 12-bit angle in Q1.15; bit 10 mirrors the quarter, bit 11 flips the sign.
   function automatic longint sine_q15(input logic [11:0] angle);
      int unsigned ramp;
      longint p;
      ramp = angle[10] ? (1024 - int'(angle[9:0])) : int'(angle[9:0]);
      p = quarter_wave(ramp);
      return angle[11] ? -p : p;
   endfunction

   task automatic predict_pose(input odo_item_type it);
      logic [24:0] total;
      logic [11:0] angle;
      longint s, c, vf, vl, w, dt, dx, dy, dh;
      pose_type p;
      if (it.op == OP_COMMAND) begin
         held_fwd = it.fwd;
         held_lat = it.lat;
         held_turn = it.turn;
         quiet_time = '0;
         command_count++;
         return;
      end
      tick_count++;
      total = {1'b0, quiet_time} + {9'd0, it.elapsed};
      quiet_time = total[24] ? 24'hFFFFFF : total[23:0];
      p.stopped = (quiet_time > wd_limit);
      if (p.stopped) begin
         held_fwd = '0;
         held_lat = '0;
         held_turn = '0;
         trip_count++;
      end
      // The rotation uses the heading from before this tick's turn.
      angle = est_heading[31:20];
      s = sine_q15(angle);
      c = sine_q15(angle + 12'd1024);
      vf = held_fwd;
      vl = held_lat;
      w = held_turn;
      dt = longint'(it.elapsed);
      dx = ((vf * c - vl * s) * dt) >>> 23;
      dy = ((vf * s + vl * c) * dt) >>> 23;
      dh = (w * dt) >>> 8;
      est_x = est_x + dx[47:0];
      est_y = est_y + dy[47:0];
      est_heading = est_heading + dh[31:0];
      p.x = est_x;
      p.y = est_y;
      p.heading = est_heading;
      p.fwd = held_fwd;
      p.lat = held_lat;
      p.turn = held_turn;
      expected_poses.push_back(p);
   endtask

   task automatic send_item(input odo_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_gaps) begin
            gap = $urandom_range(1, 30);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= it.op;
      req_cmd_forward <= it.fwd;
      req_cmd_lateral <= it.lat;
      req_cmd_turn_rate <= it.turn;
      req_elapsed <= it.elapsed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pose(it);
   endtask

   // Lets every pending result drain and the block fall idle.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_watchdog(input logic [23:0] limit);
      settle_block();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      wd_limit = limit;
      limit_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic odo_item_type command_item(input logic [23:0] f, input logic [23:0] l,
                                                 input logic [31:0] t);
      odo_item_type it;
      it.op = OP_COMMAND;
      it.fwd = f;
      it.lat = l;
      it.turn = t;
      it.elapsed = 16'($urandom());
      return it;
   endfunction

   // Command fields of a tick carry junk; the block must ignore them.
   function automatic odo_item_type tick_item(input logic [15:0] dt);
      odo_item_type it;
      it.op = OP_TICK;
      it.fwd = 24'($urandom());
      it.lat = 24'($urandom());
      it.turn = $urandom();
      it.elapsed = dt;
      return it;
   endfunction

   function automatic odo_item_type random_command();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return command_item(24'($urandom()), 24'($urandom()), $urandom());
      else if (r < 8)
         return command_item(24'(int'($urandom_range(0, 131071)) - 65536),
                             24'(int'($urandom_range(0, 131071)) - 65536),
                             32'(int'($urandom_range(0, 33554431)) - 16777216));
      else
         return command_item($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000,
                             $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000,
                             $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
   endfunction

   function automatic logic [15:0] random_elapsed();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom());
         default: return 16'($urandom_range(1, 1500));
      endcase
   endfunction

   function automatic odo_item_type random_noise();
      odo_item_type it;
      it.op = 1'($urandom());
      it.fwd = 24'($urandom());
      it.lat = 24'($urandom());
      it.turn = $urandom();
      it.elapsed = 16'($urandom());
      return it;
   endfunction

   task automatic test_reset_state();
      send_item(tick_item(16'd0));
      send_item(tick_item(16'hFFFF));
      send_item(tick_item(16'd300));
   endtask

   // A quarter-turn rate with 256 units of elapsed time moves the heading exactly one
   // quadrant per tick, so the rotation hits every quadrant edge.
   task automatic test_quadrant_edges();
      send_item(command_item(24'h400000, 24'hE00000, 32'h40000000));
      repeat (5) send_item(tick_item(16'd256));
      send_item(command_item(24'h123456, 24'h7FFFFF, 32'hC0000000));
      repeat (4) send_item(tick_item(16'd256));
   endtask

   task automatic test_field_extremes();
      write_watchdog(24'hFFFFFF);
      send_item(command_item(24'h7FFFFF, 24'h800000, 32'h7FFFFFFF));
      send_item(tick_item(16'd1));
      send_item(tick_item(16'hFFFF));
      send_item(command_item(24'h800000, 24'h7FFFFF, 32'h80000000));
      send_item(tick_item(16'hFFFF));
      send_item(tick_item(16'd0));
      send_item(command_item(24'h000000, 24'h000000, 32'h00000000));
      send_item(tick_item(16'hFFFF));
   endtask

   // With a zero limit only a tick of zero elapsed time right after a command runs.
   task automatic test_watchdog_zero();
      write_watchdog(24'd0);
      send_item(random_command());
      send_item(tick_item(16'd0));
      send_item(tick_item(16'd1));
      send_item(tick_item(16'd0));
      send_item(random_command());
      send_item(tick_item(16'hFFFF));
   endtask

   // The counter sticks at full scale, which equals the largest limit and so never trips it;
   // one step lower trips at once.
   task automatic test_counter_saturation();
      write_watchdog(24'hFFFFFF);
      send_item(random_command());
      repeat (258) send_item(tick_item(16'hFFFF));
      write_watchdog(24'hFFFFFE);
      send_item(tick_item(16'd0));
      send_item(tick_item(16'd0));
   endtask

   task automatic test_output_backpressure();
      write_watchdog(WD_LIMIT_RESET);
      sender_gaps = 1'b0;
      hold_request = HOLD_OFF_CYCLES;
      repeat (40)
         send_item(($urandom_range(0, 2) == 0) ? random_command()
                                               : tick_item(random_elapsed()));
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [23:0] limit;
      int sent, kind, n;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: limit = WD_LIMIT_RESET;
            1: limit = 24'd0;
            2: limit = 24'hFFFFFF;
            3: limit = 24'($urandom_range(500, 20000));
            default: limit = 24'($urandom());
         endcase
         write_watchdog(limit);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
               // A command followed by a run of ticks that may or may not trip the watchdog.
               n = $urandom_range(1, 12);
               send_item(random_command());
               repeat (n) send_item(tick_item(random_elapsed()));
               sent += n + 1;
            end else if (kind < 90) begin
               n = $urandom_range(1, 6);
               repeat (n) send_item(tick_item(random_elapsed()));
               sent += n;
            end else begin
               n = $urandom_range(1, 8);
               repeat (n) send_item(random_noise());
               sent += n;
            end
         end
      end
      sender_gaps = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [63:0] expected_value,
                              input logic [63:0] actual_value);
      if (expected_value !== actual_value) begin
         $error("%s: expected %h, got %h", name, expected_value, actual_value);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_poses.size() == 0) begin
            $error("pose result arrived with no tick waiting for it");
            failures++;
         end else begin
            want = expected_poses.pop_front();
            check_field("pos_x", 64'(want.x), 64'(rsp_pos_x));
            check_field("pos_y", 64'(want.y), 64'(rsp_pos_y));
            check_field("heading", 64'(want.heading), 64'(rsp_heading));
            check_field("eff_forward", 64'(want.fwd), 64'(rsp_eff_forward));
            check_field("eff_lateral", 64'(want.lat), 64'(rsp_eff_lateral));
            check_field("eff_turn_rate", 64'(want.turn), 64'(rsp_eff_turn_rate));
            check_field("stopped", 64'(want.stopped), 64'(rsp_stopped));
            poses_checked++;
         end
      end
   end

   // The receiver picks its own stall pattern; a requested hold-off overrides it.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         stall_phase++;
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_stall <= ((stall_phase % 5) < 2);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("planar_odometry_integrator_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_quadrant_edges();
      test_field_extremes();
      test_watchdog_zero();
      test_counter_saturation();
      test_output_backpressure();
      test_random_traffic();
      settle_block();
      $display("Checked %0d poses from %0d ticks and %0d commands; watchdog tripped on %0d ticks.",
               poses_checked, tick_count, command_count, trip_count);
      $display("Watchdog limit written %0d times, zero and full scale included; %0d mismatches.",
               limit_writes, failures);
      if (failures == 0)
         $display("planar_odometry_integrator_tb: PASS");
      else
         $display("planar_odometry_integrator_tb: FAIL");
      $finish;
   end

endmodule
